[rtl/core/wam_pkg.sv]
// Shared types and constants for the weekly alarm matcher.
package wam_pkg;

    // Default table depth and fixed timing constants
    localparam int ALARM_SLOTS_DEF = 10;
    localparam int SEC_W           = 17;
    localparam int WAIT_W          = 11;
    localparam int CMP_W           = 5;     // holds any index or count plus one
    localparam logic [SEC_W:0]    ALARM_WINDOW = 18'd120;
    localparam logic [WAIT_W-1:0] WAIT_CAP     = 11'd2000;
    localparam logic [2:0]        LAST_WEEKDAY = 3'd6;

    // Item operations
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_APPEND = 2'd1,
        OP_WRITE  = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_RESP  = 2'd3
    } state_t;

    // One alarm table entry
    typedef struct packed {
        logic             enable;
        logic [SEC_W-1:0] second;
        logic [6:0]       days;
        logic [7:0]       strength;
        logic             lock;
    } entry_t;

    // Verdict of the compare unit for one entry
    typedef struct packed {
        logic             active;     // enabled and armed for today
        logic             in_window;  // now within [second, second + window]
        logic             later;      // alarm second lies after now
        logic [SEC_W-1:0] gap;        // second - now, meaningful when later
    } match_t;

endpackage

[rtl/core/wam_match_unit.sv]
// Shared compare unit: checks one table entry against the current time.
module wam_match_unit
    import wam_pkg::*;
(
    input  entry_t           entry,
    input  logic [SEC_W-1:0] now,
    input  logic [2:0]       day,
    output match_t           result
);

    logic [7:0]     days_ext;
    logic [SEC_W:0] win_end;

    // Weekday seven has no mask bit, so it never matches
    assign days_ext = {1'b0, entry.days};
    assign win_end  = {1'b0, entry.second} + ALARM_WINDOW;

    always_comb
    begin
        result.active    = entry.enable && (day <= LAST_WEEKDAY) && days_ext[day];
        result.in_window = (now >= entry.second) && ({1'b0, now} <= win_end);
        result.later     = entry.second > now;
        result.gap       = entry.second - now;
    end

endmodule

[rtl/core/weekly_alarm_matcher.sv]
// Weekly alarm matcher top level: alarm table, sequencer and result register.
//
// Keeps up to ALARM_SLOTS weekly alarms and answers every input transaction
// with exactly one result transaction. Append, overwrite and a tick that
// does not scan pass from idle straight to the response state. A tick with
// a valid time and stored alarms first scans them all; a delete at a valid
// index i first shifts the entries above i down by one. The single compare
// unit visits one table entry per cycle and the delete shift moves one entry
// per cycle. The input is ready only while the sequencer is idle; a finished
// result waits in the output register while the next transaction is taken.
module weekly_alarm_matcher
    import wam_pkg::*;
#(
    parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata, from bit 0: operation[2], seconds_of_day[17], day_of_week[3],
    // time_valid[1], entry_index[4], alarm_enable[1], alarm_second[17],
    // weekday_mask[7], alarm_strength[8], zero fill[4]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata, from bit 0: status[2], fired[1], fired_slot[4],
    // fired_strength[8], wait_seconds[11], entry_count[4], zero fill[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(ALARM_SLOTS);

    // Input field split
    op_t              in_op;
    logic [SEC_W-1:0] in_now;
    logic [2:0]       in_day;
    logic             in_valid_time;
    logic [3:0]       in_idx;
    entry_t           in_entry;

    assign in_op          = op_t'(s_tdata[1:0]);
    assign in_now         = s_tdata[18:2];
    assign in_day         = s_tdata[21:19];
    assign in_valid_time  = s_tdata[22];
    assign in_idx         = s_tdata[26:23];
    assign in_entry.enable   = s_tdata[27];
    assign in_entry.second   = s_tdata[44:28];
    assign in_entry.days     = s_tdata[51:45];
    assign in_entry.strength = s_tdata[59:52];
    assign in_entry.lock     = 1'b0;

    // State
    state_t              state_reg, state_next;
    entry_t              table_reg [ALARM_SLOTS];
    logic [CMP_W-1:0]    count_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [SEC_W-1:0]    now_reg;
    logic [2:0]          day_reg;
    logic [WAIT_W-1:0]   best_reg;
    logic [WAIT_W-1:0]   held_wait_reg;
    status_t             status_reg;
    logic                fired_reg;
    logic [3:0]          fslot_reg;
    logic [7:0]          fstr_reg;
    logic                m_tvalid_reg;
    logic [31:0]         m_tdata_reg;

    // Decode of the accepted transaction
    logic             accept;
    logic             scan_go;
    logic             idx_ok;
    logic             room_ok;
    logic             k_last;
    logic             load_out;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;
    match_t           match;
    logic [IDX_W-1:0] cnt_idx;
    logic [IDX_W-1:0] in_k;

    assign accept  = s_tvalid && s_tready;
    assign scan_go = in_valid_time && (count_reg != '0);
    assign idx_ok  = CMP_W'(in_idx) < count_reg;
    assign room_ok = count_reg < SLOTS_C;
    assign k_last  = (CMP_W'(k_reg) + CMP_W'(1)) >= count_reg;
    assign cnt_idx = count_reg[IDX_W-1:0];
    assign in_k    = in_idx[IDX_W-1:0];

    // Single read port: current entry while scanning, next entry while shifting
    assign rd_idx   = (state_reg == S_SHIFT) ? (k_reg + IDX_W'(1)) : k_reg;
    assign rd_entry = table_reg[rd_idx];

    wam_match_unit u_match (
        .entry  (rd_entry),
        .now    (now_reg),
        .day    (day_reg),
        .result (match)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_op == OP_TICK && scan_go)
                        state_next = S_SCAN;
                    else if (in_op == OP_DELETE && idx_ok)
                        state_next = S_SHIFT;
                    else
                        state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (k_last)
                    state_next = S_RESP;
            end
            S_SHIFT:
            begin
                if (k_last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_SCAN:  s_tready = 1'b0;
            S_SHIFT: s_tready = 1'b0;
            S_RESP:  load_out = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            held_wait_reg <= WAIT_CAP;
            m_tvalid_reg  <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                k_reg <= (in_op == OP_DELETE) ? in_k : '0;
                if (in_op == OP_APPEND && room_ok)
                    count_reg <= count_reg + CMP_W'(1);
            end
            else if (state_reg == S_SCAN || state_reg == S_SHIFT)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end

            // Scan end commits the wait, shift end drops one entry
            if (state_reg == S_SCAN && k_last)
            begin
                if (match.active && match.later && (match.gap < SEC_W'(best_reg)))
                    held_wait_reg <= match.gap[WAIT_W-1:0];
                else
                    held_wait_reg <= best_reg;
            end
            if (state_reg == S_SHIFT && k_last)
                count_reg <= count_reg - CMP_W'(1);

            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Item payload and scan accumulators
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= in_now;
            day_reg   <= in_day;
            best_reg  <= WAIT_CAP;
            fired_reg <= 1'b0;
            fslot_reg <= '0;
            fstr_reg  <= '0;
            priority if (in_op == OP_APPEND && !room_ok)
                status_reg <= ST_FULL;
            else if ((in_op == OP_WRITE || in_op == OP_DELETE) && !idx_ok)
                status_reg <= ST_RANGE;
            else
                status_reg <= ST_OK;
        end
        else if (state_reg == S_SCAN && match.active)
        begin
            if (match.in_window && !rd_entry.lock)
            begin
                fired_reg <= 1'b1;
                fslot_reg <= 4'(k_reg);
                fstr_reg  <= rd_entry.strength;
            end
            if (match.later && (match.gap < SEC_W'(best_reg)))
                best_reg <= match.gap[WAIT_W-1:0];
        end

        if (load_out)
            m_tdata_reg <= {2'b00, 4'(count_reg), held_wait_reg, fstr_reg, fslot_reg,
                            fired_reg, status_reg};
    end

    // Alarm table
    always_ff @(posedge clk)
    begin
        if (accept && in_op == OP_APPEND && room_ok)
        begin
            table_reg[cnt_idx] <= in_entry;
        end
        else if (accept && in_op == OP_WRITE && idx_ok)
        begin
            table_reg[in_k].enable   <= in_entry.enable;
            table_reg[in_k].second   <= in_entry.second;
            table_reg[in_k].days     <= in_entry.days;
            table_reg[in_k].strength <= in_entry.strength;
        end
        else if (state_reg == S_SCAN && match.active)
        begin
            table_reg[k_reg].lock <= match.in_window;
        end
        else if (state_reg == S_SHIFT && !k_last)
        begin
            table_reg[k_reg] <= rd_entry;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("entry count above table depth");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_wait_reg <= WAIT_CAP)
        else $error("held wait above cap");

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> (CMP_W'(k_reg) < count_reg))
        else $error("sequencer index beyond stored entries");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not posted after response");

endmodule
